### sv/vtm_pkg.sv
// shared constants and register indexes of the vco tuning meter
package vtm_pkg;

  // fraction bits of the fixed-point log2
  localparam int LogFrac = 16;
  localparam int LogW    = LogFrac + 5;
  localparam int NoteW   = LogFrac + 12;
  localparam int LbW     = $clog2(LogFrac);
  localparam int RefW    = 12;
  localparam int DivW    = 37;
  localparam int DenW    = (LogFrac + 4 > 17) ? LogFrac + 4 : 17;
  localparam int DivCntW = $clog2(DivW + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [31:0] HzMin      = 32'd65536;
  localparam logic [31:0] HzMax      = 32'd1310720000;
  localparam logic [30:0] DefaultA1  = 31'd28835840;
  localparam int          PitchLimit = 335544320;
  localparam logic [16:0] AlphaMax   = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSmooth  = 3'd0,
    CfgConcert = 3'd1,
    CfgRefNote = 3'd2,
    CfgPrec    = 3'd3,
    CfgBase    = 3'd4
  } cfg_idx_e;

endpackage

### sv/vco_tuning_meter_core.sv
// vco tuning meter: frequency smoothing, log2 pitch, cents and led drive
//
// One item per tick of the probe. A valid frequency is smoothed by a one-pole
// filter, turned into semitones with a 16-step squaring log2 (run once for the
// smoothed frequency and once for concert pitch) and then into cents, tuning,
// pitches and led levels. Divisions by constants strip their power of two and
// multiply by a reciprocal; the led level divides by a variable span with a
// 37-step restoring divider. All products go through one 32x32 multiplier.
// An item with a valid frequency runs, from acceptance to the output register,
// through the filter update (when armed), the bit-by-bit normalize and squaring
// loop of each log, three or four reciprocal divisions and, when out of tune,
// the led divide. An item without signal goes straight to the output register.
// Either may wait while the previous reading is still stalled in the output
// register. The input stalls while an item is in work; a finished item waits
// in the output register, so the next item can be taken.
module vco_tuning_meter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vtm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vtm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           probe_present_i,
  input  logic [31:0]                    probe_hz_i,
  input  logic                           leds_shown_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           signal_found_o,
  output logic [30:0]                    frequency_o,
  output logic signed [29:0]             pitch_o,
  output logic signed [29:0]             reference_pitch_o,
  output logic signed [18:0]             cents_o,
  output logic signed [20:0]             tuning_o,
  output logic                           in_tune_o,
  output logic [16:0]                    led_flat_o,
  output logic [16:0]                    led_sharp_o,
  output logic                           led_in_tune_o,
  output logic                           leds_updated_o
);
  import vtm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FMUL  = 4'd1;
  localparam logic [3:0] S_FUPD  = 4'd2;
  localparam logic [3:0] S_LNORM = 4'd3;
  localparam logic [3:0] S_LSQ   = 4'd4;
  localparam logic [3:0] S_NOTE  = 4'd5;
  localparam logic [3:0] S_REF   = 4'd6;
  localparam logic [3:0] S_CENTS = 4'd7;
  localparam logic [3:0] S_DLOAD = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DDONE = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_RMUL  = 4'd12;
  localparam logic [3:0] S_RQ    = 4'd13;

  localparam logic [2:0] OP_K      = 3'd0;
  localparam logic [2:0] OP_TUNE   = 3'd1;
  localparam logic [2:0] OP_PITCH  = 3'd2;
  localparam logic [2:0] OP_RPITCH = 3'd3;
  localparam logic [2:0] OP_MAG    = 3'd4;

  // configuration
  logic [16:0]        alpha_q;
  logic [30:0]        concert_q;
  logic signed [4:0]  refnote_q;
  logic [14:0]        prec_q;
  logic signed [29:0] base_q;

  // sequencer and working registers
  logic [3:0]              state_q;
  logic [2:0]              op_q;
  logic                    phase_q;
  logic [31:0]             hz_q;
  logic                    shown_q;
  logic                    found_q;
  logic [31:0]             smooth_q;
  logic                    armed_q;
  logic [31:0]             lx_q;
  logic [4:0]              le_q;
  logic [LogFrac-1:0]      lfrac_q;
  logic [LbW-1:0]          lbit_q;
  logic                    lsel_q;
  logic [LogW-1:0]         ls_q;
  logic signed [NoteW-1:0] note_q;
  logic signed [RefW-1:0]  ref_q;
  logic signed [18:0]      cents_q;
  logic                    intune_q;
  logic signed [20:0]      tune_q;
  logic [16:0]             mag_q;
  logic signed [29:0]      hpitch_q;
  logic signed [29:0]      hrpitch_q;
  logic [63:0]             prod_q;

  // divider
  logic [DivW-1:0]    dv_num_q;
  logic [DenW-1:0]    dv_rem_q;
  logic [DenW-1:0]    dv_den_q;
  logic               dv_neg_q;
  logic [DivCntW-1:0] dv_cnt_q;
  logic [31:0]        rc_x_q;

  // output register
  logic               outv_q;
  logic               o_found_q;
  logic [30:0]        o_freq_q;
  logic signed [29:0] o_pitch_q;
  logic signed [29:0] o_rpitch_q;
  logic signed [18:0] o_cents_q;
  logic signed [20:0] o_tune_q;
  logic               o_intune_q;
  logic [16:0]        o_flat_q;
  logic [16:0]        o_sharp_q;
  logic               o_ledin_q;
  logic               o_upd_q;

  logic                    accept;
  logic                    hz_ok;
  logic [16:0]             alpha_sat;
  logic                    hz_ge;
  logic [31:0]             ad;
  logic [47:0]             fstep;
  logic [31:0]             smooth_new;
  logic [31:0]             cp;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [32:0]             sq;
  logic [LogFrac-1:0]      lfrac_set;
  logic signed [NoteW-1:0] ls_x;
  logic signed [NoteW-1:0] lc_x;
  logic signed [NoteW-1:0] note_w;
  logic [NoteW-1:0]        anote;
  logic [NoteW-1:0]        rq;
  logic signed [NoteW-1:0] dev;
  logic [NoteW-1:0]        adev;
  logic [63:0]             cm;
  logic [18:0]             ac;
  logic signed [16:0]      span_raw;
  logic [13:0]             span;
  logic [18:0]             num_raw;
  logic [13:0]             num;
  logic [15:0]             magn;
  logic signed [DivW-1:0]  dn;
  logic [DenW-1:0]         dd;
  logic [DivW-1:0]         dmag;
  logic [DivW-1:0]         dnum;
  logic [4:0]              rc_s;
  logic [31:0]             rc_m;
  logic [DivW-1:0]         rc_q;
  logic [DenW:0]           rem_sh;
  logic                    dge;
  logic [DenW:0]           rem_nx;
  logic signed [DivW-1:0]  dq;

  function automatic logic signed [29:0] sat_pitch(input logic signed [31:0] v);
    logic signed [31:0] lim;
    lim = 32'(PitchLimit);
    if (v > lim) return 30'(lim);
    if (v < -lim) return 30'(-lim);
    return v[29:0];
  endfunction

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign hz_ok      = probe_present_i && (probe_hz_i >= HzMin) && (probe_hz_i <= HzMax);

  // filter
  assign alpha_sat  = (alpha_q > AlphaMax) ? AlphaMax : alpha_q;
  assign hz_ge      = (hz_q >= smooth_q);
  assign ad         = hz_ge ? hz_q - smooth_q : smooth_q - hz_q;
  assign fstep      = 48'((prod_q + 64'd32768) >> 16);
  assign smooth_new = hz_ge ? smooth_q + fstep[31:0] : smooth_q - fstep[31:0];
  assign cp         = (concert_q == '0) ? {1'b0, DefaultA1} : {1'b0, concert_q};

  // shared multiplier operands
  always_comb begin
    case (state_q)
      S_FMUL: begin
        mul_a = {15'd0, alpha_sat};
        mul_b = ad;
      end
      S_CENTS: begin
        mul_a = 32'(adev);
        mul_b = 32'd25600;
      end
      S_RMUL: begin
        mul_a = rc_x_q;
        mul_b = rc_m;
      end
      default: begin
        mul_a = lx_q;
        mul_b = lx_q;
      end
    endcase
  end

  // log2 squaring step
  assign sq        = prod_q[63:31];
  assign lfrac_set = lfrac_q | (LogFrac'(sq[32]) << lbit_q);

  assign ls_x   = NoteW'($signed({1'b0, ls_q}));
  assign lc_x   = NoteW'($signed({1'b0, le_q, lfrac_q}));
  assign note_w = (ls_x - lc_x) * NoteW'(12) + (NoteW'(21) <<< LogFrac);

  // nearest semitone, half away from zero
  assign anote = note_q[NoteW-1] ? NoteW'(-note_q) : NoteW'(note_q);
  assign rq    = (anote + (NoteW'(1) << (LogFrac - 1))) >> LogFrac;

  assign dev  = note_q - (NoteW'(ref_q) <<< LogFrac);
  assign adev = dev[NoteW-1] ? NoteW'(-dev) : NoteW'(dev);
  assign cm   = (prod_q + (64'd1 << (LogFrac - 1))) >> LogFrac;

  // led magnitude operands
  assign ac       = cents_q[18] ? 19'(-cents_q) : 19'(cents_q);
  assign span_raw = 17'sd12800 - $signed({2'b00, prec_q});
  assign span     = (span_raw < 17'sd256) ? 14'd256 : span_raw[13:0];
  assign num_raw  = ac - {4'd0, prec_q};
  assign num      = (num_raw > {5'd0, span}) ? span : num_raw[13:0];
  assign magn     = {2'b00, span} + {num, 2'b00};

  // divider operand select
  always_comb begin
    case (op_q)
      OP_K: begin
        dn = DivW'(note_q) - (DivW'(refnote_q) <<< LogFrac);
        dd = DenW'(12) << LogFrac;
      end
      OP_TUNE: begin
        dn = DivW'(cents_q) <<< 16;
        dd = DenW'(12000);
      end
      OP_PITCH: begin
        dn = DivW'(note_q) <<< (24 - LogFrac);
        dd = DenW'(120);
      end
      OP_RPITCH: begin
        dn = DivW'(ref_q) <<< 24;
        dd = DenW'(120);
      end
      OP_MAG: begin
        dn = $signed(DivW'({magn, 16'd0}));
        dd = DenW'(span) * DenW'(5);
      end
      default: begin
        dn = '0;
        dd = DenW'(1);
      end
    endcase
  end

  // divisions by constants: strip the power of two, then multiply by a reciprocal
  always_comb begin
    case (op_q)
      OP_K: begin
        rc_s = 5'(LogFrac + 2);
        rc_m = 32'd2863311531;
        rc_q = DivW'(prod_q >> 33);
      end
      OP_TUNE: begin
        rc_s = 5'd5;
        rc_m = 32'd2932031008;
        rc_q = DivW'(prod_q >> 40);
      end
      default: begin
        rc_s = 5'd3;
        rc_m = 32'd2290649225;
        rc_q = DivW'(prod_q >> 35);
      end
    endcase
  end

  assign dmag   = dn[DivW-1] ? DivW'(-dn) : DivW'(dn);
  assign dnum   = dmag + DivW'(dd >> 1);
  assign rem_sh = {dv_rem_q, dv_num_q[DivW-1]};
  assign dge    = (rem_sh >= {1'b0, dv_den_q});
  assign rem_nx = dge ? rem_sh - {1'b0, dv_den_q} : rem_sh;
  assign dq     = dv_neg_q ? -$signed(dv_num_q) : $signed(dv_num_q);

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= AlphaMax;
      concert_q <= DefaultA1;
      refnote_q <= -5'sd1;
      prec_q    <= '0;
      base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSmooth:  alpha_q   <= cfg_data_i[16:0];
        CfgConcert: concert_q <= cfg_data_i[30:0];
        CfgRefNote: refnote_q <= cfg_data_i[4:0];
        CfgPrec:    prec_q    <= cfg_data_i[14:0];
        CfgBase:    base_q    <= cfg_data_i[29:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      armed_q   <= 1'b0;
      smooth_q  <= '0;
      hpitch_q  <= '0;
      hrpitch_q <= '0;
      outv_q    <= 1'b0;
    end else begin
      if (outv_q && !out_stall_i && state_q != S_OUT) outv_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            hz_q    <= probe_hz_i;
            shown_q <= leds_shown_i;
            found_q <= hz_ok;
            armed_q <= hz_ok;
            if (!hz_ok) begin
              state_q <= S_OUT;
            end else if (armed_q) begin
              state_q <= S_FMUL;
            end else begin
              smooth_q <= probe_hz_i;
              lx_q     <= probe_hz_i;
              le_q     <= 5'd31;
              lfrac_q  <= '0;
              lsel_q   <= 1'b0;
              state_q  <= S_LNORM;
            end
          end
        end
        S_FMUL: state_q <= S_FUPD;
        S_FUPD: begin
          smooth_q <= smooth_new;
          lx_q     <= smooth_new;
          le_q     <= 5'd31;
          lfrac_q  <= '0;
          lsel_q   <= 1'b0;
          state_q  <= S_LNORM;
        end
        S_LNORM: begin
          if (!lx_q[31] && le_q != 5'd0) begin
            lx_q <= {lx_q[30:0], 1'b0};
            le_q <= le_q - 5'd1;
          end else begin
            lbit_q  <= LbW'(LogFrac - 1);
            phase_q <= 1'b0;
            state_q <= S_LSQ;
          end
        end
        S_LSQ: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            lx_q    <= sq[32] ? sq[32:1] : sq[31:0];
            lfrac_q <= lfrac_set;
            lbit_q  <= lbit_q - LbW'(1);
            if (lbit_q == '0) begin
              if (!lsel_q) begin
                ls_q    <= {le_q, lfrac_set};
                lx_q    <= cp;
                le_q    <= 5'd31;
                lfrac_q <= '0;
                lsel_q  <= 1'b1;
                state_q <= S_LNORM;
              end else begin
                state_q <= S_NOTE;
              end
            end
          end
        end
        S_NOTE: begin
          note_q  <= note_w;
          state_q <= S_REF;
        end
        S_REF: begin
          if (refnote_q[4]) begin
            ref_q   <= note_q[NoteW-1] ? RefW'(-rq) : RefW'(rq);
            phase_q <= 1'b0;
            state_q <= S_CENTS;
          end else begin
            op_q    <= OP_K;
            state_q <= S_DLOAD;
          end
        end
        S_CENTS: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            cents_q  <= dev[NoteW-1] ? 19'(-cm) : 19'(cm);
            intune_q <= (cm <= 64'(prec_q));
            op_q     <= OP_TUNE;
            state_q  <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dv_neg_q <= dn[DivW-1];
          if (op_q == OP_MAG) begin
            dv_num_q <= dnum;
            dv_den_q <= dd;
            dv_rem_q <= '0;
            dv_cnt_q <= DivCntW'(DivW);
            state_q  <= S_DIV;
          end else begin
            rc_x_q  <= 32'(dnum >> rc_s);
            state_q <= S_RMUL;
          end
        end
        S_RMUL: state_q <= S_RQ;
        S_RQ: begin
          dv_num_q <= rc_q;
          state_q  <= S_DDONE;
        end
        S_DIV: begin
          dv_rem_q <= rem_nx[DenW-1:0];
          dv_num_q <= {dv_num_q[DivW-2:0], dge};
          dv_cnt_q <= dv_cnt_q - DivCntW'(1);
          if (dv_cnt_q == DivCntW'(1)) state_q <= S_DDONE;
        end
        S_DDONE: begin
          case (op_q)
            OP_K: begin
              ref_q   <= RefW'(refnote_q) + $signed(dq[RefW-1:0]) * RefW'(12);
              phase_q <= 1'b0;
              state_q <= S_CENTS;
            end
            OP_TUNE: begin
              tune_q  <= dq[20:0];
              op_q    <= OP_PITCH;
              state_q <= S_DLOAD;
            end
            OP_PITCH: begin
              hpitch_q <= sat_pitch(32'(base_q) + $signed(dq[31:0]));
              op_q     <= OP_RPITCH;
              state_q  <= S_DLOAD;
            end
            OP_RPITCH: begin
              hrpitch_q <= sat_pitch(32'(base_q) + $signed(dq[31:0]));
              if (intune_q) begin
                mag_q   <= '0;
                state_q <= S_OUT;
              end else begin
                op_q    <= OP_MAG;
                state_q <= S_DLOAD;
              end
            end
            OP_MAG: begin
              mag_q   <= dq[16:0];
              state_q <= S_OUT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_OUT: begin
          if (!outv_q || !out_stall_i) begin
            outv_q     <= 1'b1;
            o_found_q  <= found_q;
            o_freq_q   <= found_q ? smooth_q[30:0] : '0;
            o_pitch_q  <= hpitch_q;
            o_rpitch_q <= hrpitch_q;
            o_cents_q  <= found_q ? cents_q : '0;
            o_tune_q   <= found_q ? tune_q : '0;
            o_intune_q <= found_q && intune_q;
            o_flat_q   <= (found_q && shown_q && !intune_q && cents_q < 0) ? mag_q : '0;
            o_sharp_q  <= (found_q && shown_q && !intune_q && cents_q > 0) ? mag_q : '0;
            o_ledin_q  <= found_q && shown_q && intune_q;
            o_upd_q    <= shown_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = outv_q;
  assign signal_found_o    = o_found_q;
  assign frequency_o       = o_freq_q;
  assign pitch_o           = o_pitch_q;
  assign reference_pitch_o = o_rpitch_q;
  assign cents_o           = o_cents_q;
  assign tuning_o          = o_tune_q;
  assign in_tune_o         = o_intune_q;
  assign led_flat_o        = o_flat_q;
  assign led_sharp_o       = o_sharp_q;
  assign led_in_tune_o     = o_ledin_q;
  assign leds_updated_o    = o_upd_q;

endmodule
